// ----- rtl/gas_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Shared types and constants of the grid path search unit.
// No dependencies; used by the unit, its ranking unit and the testbench.
package gas_pkg;

  localparam int COORD_W     = 3;
  localparam int CELL_W      = 6;
  localparam int CELLS       = 64;
  localparam int ROWS        = 8;
  localparam int G_W         = 10;
  localparam int H_W         = 8;
  localparam int F_W         = 11;
  localparam int STEP_COST   = 10;
  localparam int DEF_MAX_WIDTH  = 8;
  localparam int DEF_MAX_HEIGHT = 8;

  localparam logic [1:0] CFG_GRID_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_GRID_HEIGHT = 2'd1;

  localparam logic [2:0] ST_OK            = 3'd0;
  localparam logic [2:0] ST_START_OUT     = 3'd1;
  localparam logic [2:0] ST_GOAL_OUT      = 3'd2;
  localparam logic [2:0] ST_START_BLOCKED = 3'd3;
  localparam logic [2:0] ST_GOAL_BLOCKED  = 3'd4;
  localparam logic [2:0] ST_NO_PATH       = 3'd5;

  typedef struct packed {
    logic [G_W-1:0]    g;
    logic [H_W-1:0]    h;
    logic [CELL_W-1:0] idx;
  } rank_entry_t;

endpackage
`default_nettype wire

// ----- rtl/gas_cell_mem.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Per-cell memory with one write port and one registered read port.
// Depends on nothing outside itself.
module gas_cell_mem #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- rtl/gas_rank.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Ranking compare used by the open-list scan: lower f, then lower h wins.
// Depends on gas_pkg. Cells arrive in rising order, so a tie keeps the best.
module gas_rank (
  input  wire logic                 have_best,
  input  gas_pkg::rank_entry_t      best,
  input  gas_pkg::rank_entry_t      cand,
  output logic                      better
);
  import gas_pkg::*;

  logic [F_W-1:0] f_best;
  logic [F_W-1:0] f_cand;

  always_comb begin
    f_best = F_W'(best.g) + F_W'(best.h);
    f_cand = F_W'(cand.g) + F_W'(cand.h);
    better = !have_best || (f_cand < f_best) || ((f_cand == f_best) && (cand.h < best.h));
  end

endmodule
`default_nettype wire

// ----- rtl/grid_astar_path_search_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// A* path search over a grid of up to 8 x 8 cells. A load item writes one map row
// and gives no result. A query item runs a search: each expansion scans all 64 cell
// records through the one read port of the cost memory and then tries four
// neighbours; the search is followed by the parent walk and by the delivery of the
// results. The block takes no item while a query is in progress; configuration
// writes are always taken.
module grid_astar_path_search_unit #(
  parameter int MAX_WIDTH  = gas_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = gas_pkg::DEF_MAX_HEIGHT
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [1:0] cfg_index,
  input  wire logic [3:0] cfg_data,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic       kind,
  input  wire logic [2:0] row_index,
  input  wire logic [7:0] blocked_row,
  input  wire logic [7:0] occupied_row,
  input  wire logic [3:0] start_x,
  input  wire logic [3:0] start_y,
  input  wire logic [3:0] goal_x,
  input  wire logic [3:0] goal_y,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic      [2:0] status,
  output logic      [2:0] step_x,
  output logic      [2:0] step_y,
  output logic      [5:0] step_number,
  output logic            last
);
  import gas_pkg::*;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_CHK_S    = 4'd1;
  localparam logic [3:0] S_CHK_G    = 4'd2;
  localparam logic [3:0] S_INIT     = 4'd3;
  localparam logic [3:0] S_SCAN     = 4'd4;
  localparam logic [3:0] S_PICK     = 4'd5;
  localparam logic [3:0] S_NB_RD    = 4'd6;
  localparam logic [3:0] S_NB_WR    = 4'd7;
  localparam logic [3:0] S_PATH_WR  = 4'd8;
  localparam logic [3:0] S_PATH_RD  = 4'd9;
  localparam logic [3:0] S_OUT_RD   = 4'd10;
  localparam logic [3:0] S_OUT_LD   = 4'd11;
  localparam logic [3:0] S_OUT_WAIT = 4'd12;

  localparam logic [1:0] DIR_UP    = 2'd0;
  localparam logic [1:0] DIR_LEFT  = 2'd1;
  localparam logic [1:0] DIR_RIGHT = 2'd2;
  localparam logic [1:0] DIR_DOWN  = 2'd3;

  localparam logic [3:0] MAX_W4 = 4'(MAX_WIDTH);
  localparam logic [3:0] MAX_H4 = 4'(MAX_HEIGHT);

  function automatic logic [H_W-1:0] manhattan(input logic [3:0] ax, input logic [3:0] ay,
                                                input logic [3:0] bx, input logic [3:0] by);
    logic [3:0] dx;
    logic [3:0] dy;
    logic [H_W-1:0] s;
    dx = (ax >= bx) ? (ax - bx) : (bx - ax);
    dy = (ay >= by) ? (ay - by) : (by - ay);
    s  = H_W'(dx) + H_W'(dy);
    return (s << 3) + (s << 1);
  endfunction

  logic [3:0]  state;
  logic [3:0]  cfg_w;
  logic [3:0]  cfg_h;
  logic [7:0]  blocked_map  [ROWS];
  logic [7:0]  occupied_map [ROWS];
  logic [3:0]  sx, sy, gx, gy;
  logic [CELLS-1:0] open_mark;
  logic [CELLS-1:0] closed_mark;
  logic [6:0]  scan_cnt;
  logic        pend;
  logic [CELL_W-1:0] pend_idx;
  logic        found;
  logic [CELL_W-1:0] best_idx;
  logic [G_W-1:0]    best_g;
  logic [H_W-1:0]    best_h;
  logic [1:0]  dir;
  logic [CELL_W-1:0] cur;
  logic [6:0]  path_cnt;
  logic [6:0]  out_idx;

  logic [3:0]  w_eff, h_eff;
  logic [6:0]  n_cells;
  logic [2:0]  map_x, map_y;
  logic        blk_bit, occ_bit;
  logic [3:0]  cx, cy, nx, ny;
  logic        nb_edge, nb_ok, nb_is_goal;
  logic [CELL_W-1:0] nb_cell, start_cell, goal_cell;
  logic [G_W-1:0]    tg;
  logic        better;
  rank_entry_t best_ent, cand_ent;

  logic              cost_we;
  logic [CELL_W-1:0] cost_waddr, cost_raddr;
  logic [G_W+H_W-1:0] cost_wdata, cost_rdata;
  logic              par_we;
  logic [CELL_W-1:0] par_rdata;
  logic              pb_we;
  logic [CELL_W-1:0] pb_raddr, pb_rdata;
  logic [6:0]        pb_rd_full;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);

  always_comb begin
    w_eff = (cfg_w == 4'd0) ? 4'd1 : ((cfg_w > MAX_W4) ? MAX_W4 : cfg_w);
    h_eff = (cfg_h == 4'd0) ? 4'd1 : ((cfg_h > MAX_H4) ? MAX_H4 : cfg_h);
    n_cells = 7'({3'd0, w_eff} * {3'd0, h_eff});
    start_cell = {sy[2:0], sx[2:0]};
    goal_cell  = {gy[2:0], gx[2:0]};

    cx = {1'b0, best_idx[2:0]};
    cy = {1'b0, best_idx[5:3]};
    nx = cx;
    ny = cy;
    nb_edge = 1'b0;
    case (dir)
      DIR_UP: begin
        nb_edge = (cy == 4'd0);
        ny = cy - 4'd1;
      end
      DIR_LEFT: begin
        nb_edge = (cx == 4'd0);
        nx = cx - 4'd1;
      end
      DIR_RIGHT: nx = cx + 4'd1;
      DIR_DOWN:  ny = cy + 4'd1;
      default:   nb_edge = 1'b1;
    endcase
    nb_cell    = {ny[2:0], nx[2:0]};
    nb_is_goal = (nx == gx) && (ny == gy);

    case (state)
      S_CHK_S: begin
        map_x = sx[2:0];
        map_y = sy[2:0];
      end
      S_CHK_G: begin
        map_x = gx[2:0];
        map_y = gy[2:0];
      end
      default: begin
        map_x = nx[2:0];
        map_y = ny[2:0];
      end
    endcase
    blk_bit = blocked_map[map_y][map_x];
    occ_bit = occupied_map[map_y][map_x];

    nb_ok = !nb_edge && (nx < w_eff) && (ny < h_eff) && !blk_bit
            && !(occ_bit && !nb_is_goal) && !closed_mark[nb_cell];
    tg = best_g + G_W'(STEP_COST);

    cost_raddr = (state == S_SCAN) ? scan_cnt[CELL_W-1:0] : nb_cell;
    cost_we    = 1'b0;
    cost_waddr = nb_cell;
    cost_wdata = {tg, manhattan(nx, ny, gx, gy)};
    par_we     = 1'b0;
    if (state == S_INIT) begin
      cost_we    = 1'b1;
      cost_waddr = start_cell;
      cost_wdata = {{G_W{1'b0}}, manhattan(sx, sy, gx, gy)};
    end else if (state == S_NB_WR) begin
      cost_we = !open_mark[nb_cell] || (tg < cost_rdata[G_W+H_W-1:H_W]);
      par_we  = cost_we;
    end
    pb_we      = (state == S_PATH_WR);
    pb_rd_full = path_cnt - 7'd1 - out_idx;
    pb_raddr   = pb_rd_full[CELL_W-1:0];

    best_ent = '{g: best_g, h: best_h, idx: best_idx};
    cand_ent = '{g: cost_rdata[G_W+H_W-1:H_W], h: cost_rdata[H_W-1:0], idx: pend_idx};
  end

  gas_rank u_rank (
    .have_best (found),
    .best      (best_ent),
    .cand      (cand_ent),
    .better    (better)
  );

  gas_cell_mem #(.WIDTH(G_W + H_W), .DEPTH(CELLS)) u_cost_mem (
    .clk   (clk),
    .we    (cost_we),
    .waddr (cost_waddr),
    .wdata (cost_wdata),
    .raddr (cost_raddr),
    .rdata (cost_rdata)
  );

  gas_cell_mem #(.WIDTH(CELL_W), .DEPTH(CELLS)) u_parent_mem (
    .clk   (clk),
    .we    (par_we),
    .waddr (nb_cell),
    .wdata (best_idx),
    .raddr (cur),
    .rdata (par_rdata)
  );

  gas_cell_mem #(.WIDTH(CELL_W), .DEPTH(CELLS)) u_path_mem (
    .clk   (clk),
    .we    (pb_we),
    .waddr (path_cnt[CELL_W-1:0]),
    .wdata (cur),
    .raddr (pb_raddr),
    .rdata (pb_rdata)
  );

  // Map rows; a row number at or above MAX_HEIGHT is dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < ROWS; r++) begin
        blocked_map[r]  <= '0;
        occupied_map[r] <= '0;
      end
    end else if (in_valid && in_ready && !kind && (32'(row_index) < MAX_HEIGHT)) begin
      blocked_map[row_index]  <= blocked_row;
      occupied_map[row_index] <= occupied_row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_w <= 4'd8;
      cfg_h <= 4'd8;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_GRID_WIDTH:  cfg_w <= cfg_data;
        CFG_GRID_HEIGHT: cfg_h <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      out_valid   <= 1'b0;
      open_mark   <= '0;
      closed_mark <= '0;
      pend        <= 1'b0;
      found       <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid && kind) begin
            sx <= start_x;
            sy <= start_y;
            gx <= goal_x;
            gy <= goal_y;
            state <= S_CHK_S;
          end
        end
        S_CHK_S: begin
          step_x <= '0;
          step_y <= '0;
          step_number <= '0;
          last <= 1'b1;
          if (sx >= w_eff || sy >= h_eff) begin
            status <= ST_START_OUT;
            out_valid <= 1'b1;
            state <= S_OUT_WAIT;
          end else if (gx >= w_eff || gy >= h_eff) begin
            status <= ST_GOAL_OUT;
            out_valid <= 1'b1;
            state <= S_OUT_WAIT;
          end else if (blk_bit || occ_bit) begin
            status <= ST_START_BLOCKED;
            out_valid <= 1'b1;
            state <= S_OUT_WAIT;
          end else begin
            status <= ST_OK;
            state <= S_CHK_G;
          end
        end
        S_CHK_G: begin
          if (blk_bit) begin
            status <= ST_GOAL_BLOCKED;
            out_valid <= 1'b1;
            state <= S_OUT_WAIT;
          end else if (sx == gx && sy == gy) begin
            step_x <= sx[2:0];
            step_y <= sy[2:0];
            out_valid <= 1'b1;
            state <= S_OUT_WAIT;
          end else begin
            state <= S_INIT;
          end
        end
        S_INIT: begin
          open_mark   <= {{(CELLS-1){1'b0}}, 1'b1} << start_cell;
          closed_mark <= '0;
          scan_cnt <= '0;
          pend  <= 1'b0;
          found <= 1'b0;
          state <= S_SCAN;
        end
        S_SCAN: begin
          // The read issued in the previous cycle is ranked here.
          if (pend && open_mark[pend_idx] && better) begin
            found    <= 1'b1;
            best_idx <= pend_idx;
            best_g   <= cand_ent.g;
            best_h   <= cand_ent.h;
          end
          if (scan_cnt != 7'(CELLS)) begin
            pend     <= 1'b1;
            pend_idx <= scan_cnt[CELL_W-1:0];
            scan_cnt <= scan_cnt + 7'd1;
          end else begin
            pend  <= 1'b0;
            state <= S_PICK;
          end
        end
        S_PICK: begin
          if (!found) begin
            status <= ST_NO_PATH;
            out_valid <= 1'b1;
            state <= S_OUT_WAIT;
          end else begin
            open_mark[best_idx]   <= 1'b0;
            closed_mark[best_idx] <= 1'b1;
            dir <= DIR_UP;
            if (best_idx == goal_cell) begin
              cur <= goal_cell;
              path_cnt <= '0;
              state <= S_PATH_WR;
            end else begin
              state <= S_NB_RD;
            end
          end
        end
        S_NB_RD: begin
          if (nb_ok) begin
            state <= S_NB_WR;
          end else if (dir == DIR_DOWN) begin
            scan_cnt <= '0;
            found <= 1'b0;
            state <= S_SCAN;
          end else begin
            dir <= dir + 2'd1;
          end
        end
        S_NB_WR: begin
          if (cost_we) begin
            open_mark[nb_cell] <= 1'b1;
          end
          if (dir == DIR_DOWN) begin
            scan_cnt <= '0;
            found <= 1'b0;
            state <= S_SCAN;
          end else begin
            dir <= dir + 2'd1;
            state <= S_NB_RD;
          end
        end
        S_PATH_WR: begin
          path_cnt <= path_cnt + 7'd1;
          if (cur == start_cell || (path_cnt + 7'd1) >= n_cells) begin
            out_idx <= '0;
            state <= S_OUT_RD;
          end else begin
            state <= S_PATH_RD;
          end
        end
        S_PATH_RD: begin
          cur <= par_rdata;
          state <= S_PATH_WR;
        end
        S_OUT_RD: state <= S_OUT_LD;
        S_OUT_LD: begin
          status      <= ST_OK;
          step_x      <= pb_rdata[2:0];
          step_y      <= pb_rdata[5:3];
          step_number <= out_idx[5:0];
          last        <= (out_idx + 7'd1 == path_cnt);
          out_valid   <= 1'b1;
          state       <= S_OUT_WAIT;
        end
        S_OUT_WAIT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            if (last) begin
              state <= S_IDLE;
            end else begin
              out_idx <= out_idx + 7'd1;
              state <= S_OUT_RD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- rtl/gas_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Port-level checks of the grid path search unit, bound to its top level.
// Depends only on the top level's ports.
module gas_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [2:0] status,
  input wire logic [2:0] step_x,
  input wire logic [2:0] step_y,
  input wire logic [5:0] step_number,
  input wire logic       last
);

  // A held result keeps its status, step number and last flag until taken.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(step_number)
    && $stable(last))
    else $error("result changed while stalled");

  // The block only takes a new item once every result of the last one is gone.
  a_idle: assert property (@(posedge clk) disable iff (rst) in_ready |-> !out_valid)
    else $error("input taken while a result is pending");

  a_fail: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != 3'd0 |-> last && step_x == 3'd0 && step_y == 3'd0
    && step_number == 6'd0)
    else $error("failure result is not a single zeroed item");

  a_rst: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result shown after reset");

endmodule

bind grid_astar_path_search_unit gas_checker u_gas_checker (.*);
`default_nettype wire

// ----- tb/grid_astar_path_search_unit_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench of the grid path search unit: it predicts every path
// step and status of each query and compares them with the results of the unit.
// Depends on gas_pkg and grid_astar_path_search_unit.
module grid_astar_path_search_unit_tb;
  import gas_pkg::*;

  typedef struct packed {
    logic [2:0] st;
    logic [2:0] x;
    logic [2:0] y;
    logic [5:0] n;
    logic       lst;
  } step_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [3:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic kind = 1'b0;
  logic [2:0] row_index = '0;
  logic [7:0] blocked_row = '0;
  logic [7:0] occupied_row = '0;
  logic [3:0] start_x = '0, start_y = '0, goal_x = '0, goal_y = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [2:0] status, step_x, step_y;
  logic [5:0] step_number;
  logic last;

  always #4 clk = ~clk;

  grid_astar_path_search_unit DUT (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .kind(kind), .row_index(row_index),
    .blocked_row(blocked_row), .occupied_row(occupied_row),
    .start_x(start_x), .start_y(start_y), .goal_x(goal_x), .goal_y(goal_y),
    .out_valid(out_valid), .out_ready(out_ready), .status(status),
    .step_x(step_x), .step_y(step_y), .step_number(step_number), .last(last)
  );

  // Predictor state.
  logic [7:0] blk_map [ROWS];
  logic [7:0] occ_map [ROWS];
  logic [3:0] width_reg = 4'd8;
  logic [3:0] height_reg = 4'd8;
  step_t expected_steps [$];
  int errors = 0;
  int idle_cycles = 0;
  bit stall_on = 1'b1;
  int taken_count = 0;
  int seen_count = 0;
  int rx_wait = 0;

  initial for (int r = 0; r < ROWS; r++) begin
    blk_map[r] = '0;
    occ_map[r] = '0;
  end

  function automatic int eff_size(logic [3:0] v);
    if (v == 0) return 1;
    if (v > 8) return 8;
    return v;
  endfunction

  function automatic int dist10(int ax, int ay, int bx, int by);
    return ((ax > bx ? ax - bx : bx - ax) + (ay > by ? ay - by : by - ay)) * STEP_COST;
  endfunction

  function automatic step_t mk(logic [2:0] st, int x, int y, int n, bit l);
    step_t s;
    s.st = st; s.x = x[2:0]; s.y = y[2:0]; s.n = n[5:0]; s.lst = l;
    return s;
  endfunction

  function automatic void add_step(step_t s);
    expected_steps.insert(expected_steps.size(), s);
  endfunction

  // Works out the results of one query and queues them.
  task automatic predict_path(int sx, int sy, int gx, int gy);
    int w, h, n, start_c, goal_c, best, bf, bh, cx, cy, nx, ny, nc, tg, f, cnt, c;
    int gcost [CELLS];
    int hcost [CELLS];
    int par [CELLS];
    bit opn [CELLS];
    bit cls [CELLS];
    int trail [CELLS];
    w = eff_size(width_reg);
    h = eff_size(height_reg);
    n = w * h;
    if (sx >= w || sy >= h) begin
      add_step(mk(ST_START_OUT, 0, 0, 0, 1)); return;
    end
    if (gx >= w || gy >= h) begin
      add_step(mk(ST_GOAL_OUT, 0, 0, 0, 1)); return;
    end
    if (blk_map[sy][sx] || occ_map[sy][sx]) begin
      add_step(mk(ST_START_BLOCKED, 0, 0, 0, 1)); return;
    end
    if (blk_map[gy][gx]) begin
      add_step(mk(ST_GOAL_BLOCKED, 0, 0, 0, 1)); return;
    end
    if (sx == gx && sy == gy) begin
      add_step(mk(ST_OK, sx, sy, 0, 1)); return;
    end
    for (int i = 0; i < CELLS; i++) begin
      gcost[i] = 0; hcost[i] = 0; par[i] = 0; opn[i] = 0; cls[i] = 0;
    end
    start_c = sy * w + sx;
    goal_c = gy * w + gx;
    hcost[start_c] = dist10(sx, sy, gx, gy);
    opn[start_c] = 1;
    forever begin
      best = -1; bf = 0; bh = 0;
      for (int i = 0; i < n; i++) begin
        if (!opn[i]) continue;
        f = gcost[i] + hcost[i];
        if (best < 0 || f < bf || (f == bf && hcost[i] < bh)) begin
          best = i; bf = f; bh = hcost[i];
        end
      end
      if (best < 0) begin
        add_step(mk(ST_NO_PATH, 0, 0, 0, 1)); return;
      end
      opn[best] = 0;
      cls[best] = 1;
      if (best == goal_c) break;
      cx = best % w;
      cy = best / w;
      // Neighbours are tried up, left, right, down.
      for (int d = 0; d < 4; d++) begin
        nx = cx; ny = cy;
        if (d == 0) begin if (cy == 0) continue; ny = cy - 1; end
        else if (d == 1) begin if (cx == 0) continue; nx = cx - 1; end
        else if (d == 2) nx = cx + 1;
        else ny = cy + 1;
        if (nx >= w || ny >= h) continue;
        if (blk_map[ny][nx]) continue;
        if (!(nx == gx && ny == gy) && occ_map[ny][nx]) continue;
        nc = ny * w + nx;
        if (cls[nc]) continue;
        tg = (gcost[best] + STEP_COST) & 10'h3FF;
        if (!opn[nc] || tg < gcost[nc]) begin
          par[nc] = best; gcost[nc] = tg; hcost[nc] = dist10(nx, ny, gx, gy);
          opn[nc] = 1;
        end
      end
    end
    cnt = 0;
    c = goal_c;
    forever begin
      trail[cnt] = c;
      cnt++;
      if (c == start_c || cnt >= n) break;
      c = par[c];
    end
    for (int i = 0; i < cnt; i++)
      add_step(mk(ST_OK, trail[cnt-1-i] % w, trail[cnt-1-i] / w, i, i + 1 == cnt));
  endtask

  task automatic send_item(bit k, int row, int b, int o, int sx, int sy, int gx, int gy);
    int gap;
    gap = $urandom_range(0, 5);
    // The valid of the previous item drops at a falling edge, and the next item
    // is driven at a later falling edge.
    repeat (gap + 1) @(negedge clk);
    kind <= k; row_index <= 3'(row); blocked_row <= 8'(b); occupied_row <= 8'(o);
    start_x <= 4'(sx); start_y <= 4'(sy); goal_x <= 4'(gx); goal_y <= 4'(gy);
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (k) predict_path(sx, sy, gx, gy);
    else begin
      blk_map[row] = 8'(b);
      occ_map[row] = 8'(o);
    end
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic load_row(int row, int b, int o);
    send_item(0, row, b, o, $urandom_range(0, 15), $urandom_range(0, 15),
              $urandom_range(0, 15), $urandom_range(0, 15));
  endtask

  task automatic query(int sx, int sy, int gx, int gy);
    send_item(1, $urandom_range(0, 7), $urandom_range(0, 255), $urandom_range(0, 255),
              sx, sy, gx, gy);
  endtask

  task automatic wait_drained();
    while (expected_steps.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, int val);
    wait_drained();
    cfg_index <= idx; cfg_data <= 4'(val); cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_GRID_WIDTH) width_reg = 4'(val);
    else width_reg = width_reg;
    if (idx == CFG_GRID_HEIGHT) height_reg = 4'(val);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic clear_map();
    for (int r = 0; r < ROWS; r++) load_row(r, 0, 0);
  endtask

  task automatic test_directed();
    query(0, 0, 7, 7);
    query(7, 7, 0, 0);
    query(3, 3, 3, 3);
    query(8, 0, 1, 1);
    query(15, 15, 15, 15);
    query(0, 0, 0, 9);
    load_row(2, 8'hFE, 8'h00);
    load_row(4, 8'h7F, 8'h80);
    query(0, 0, 0, 7);
    query(1, 2, 0, 0);
    query(7, 4, 0, 0);
    query(0, 0, 7, 4);
    load_row(5, 8'hFF, 8'h00);
    query(0, 0, 3, 7);
    load_row(5, 8'h00, 8'hFF);
    query(0, 0, 3, 7);
    query(0, 0, 3, 5);
    clear_map();
  endtask

  task automatic test_sizes();
    write_reg(CFG_GRID_WIDTH, 1);
    write_reg(CFG_GRID_HEIGHT, 1);
    query(0, 0, 0, 0);
    query(0, 0, 1, 0);
    write_reg(CFG_GRID_WIDTH, 0);
    write_reg(CFG_GRID_HEIGHT, 8);
    query(0, 0, 0, 7);
    write_reg(CFG_GRID_WIDTH, 15);
    write_reg(CFG_GRID_HEIGHT, 2);
    query(0, 0, 7, 1);
    query(0, 2, 0, 0);
    write_reg(CFG_GRID_WIDTH, 3);
    write_reg(CFG_GRID_HEIGHT, 5);
    query(2, 4, 0, 0);
  endtask

  // Random maps and queries; most queries stay inside the grid in use.
  task automatic test_random(int items, int dens);
    for (int i = 0; i < items; i++) begin
      if ($urandom_range(0, 3) == 0)
        load_row($urandom_range(0, 7), $urandom_range(0, 255) & $urandom_range(0, 255)
                 & (dens ? 8'hFF : $urandom_range(0, 255)),
                 $urandom_range(0, 255) & $urandom_range(0, 255) & $urandom_range(0, 255));
      else if ($urandom_range(0, 7) == 0)
        query($urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(0, 15),
              $urandom_range(0, 15));
      else
        query($urandom_range(0, eff_size(width_reg) - 1),
              $urandom_range(0, eff_size(height_reg) - 1),
              $urandom_range(0, eff_size(width_reg) - 1),
              $urandom_range(0, eff_size(height_reg) - 1));
    end
  endtask

  // Receiver: after each result taken it draws how many cycles to hold off.
  always @(negedge clk) begin
    if (seen_count != taken_count) begin
      seen_count = taken_count;
      rx_wait = $urandom_range(0, 5);
    end
    if (rst || !stall_on) out_ready <= 1'b1;
    else if (rx_wait > 0) begin
      out_ready <= 1'b0;
      if (out_valid) rx_wait--;
    end else out_ready <= 1'b1;
  end

  always @(posedge clk) begin
    step_t got, want;
    if (!rst && out_valid && out_ready) begin
      taken_count++;
      got = {status, step_x, step_y, step_number, last};
      if (expected_steps.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
      end else begin
        want = expected_steps.pop_front();
        if (got.st !== want.st) begin
          $display("%0t: status expected %0d actual %0d", $time, want.st, got.st);
          errors++;
        end
        if (got.x !== want.x) begin
          $display("%0t: step_x expected %0d actual %0d", $time, want.x, got.x);
          errors++;
        end
        if (got.y !== want.y) begin
          $display("%0t: step_y expected %0d actual %0d", $time, want.y, got.y);
          errors++;
        end
        if (got.n !== want.n) begin
          $display("%0t: step_number expected %0d actual %0d", $time, want.n, got.n);
          errors++;
        end
        if (got.lst !== want.lst) begin
          $display("%0t: last expected %0d actual %0d", $time, want.lst, got.lst);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles with no handshake of any kind.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 60000) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_sizes();
    write_reg(CFG_GRID_WIDTH, 8);
    write_reg(CFG_GRID_HEIGHT, 8);
    test_random(40, 0);
    wait_drained();
    stall_on = 1'b0;
    test_random(15, 1);
    stall_on = 1'b1;
    write_reg(CFG_GRID_WIDTH, 5);
    write_reg(CFG_GRID_HEIGHT, 6);
    test_random(25, 0);
    write_reg(CFG_GRID_WIDTH, 8);
    write_reg(CFG_GRID_HEIGHT, 3);
    test_random(15, 0);
    wait_drained();
    repeat (100) @(negedge clk);
    if (errors == 0 && expected_steps.size() == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
